@@ hdl/cdud_pkg.sv @@
`timescale 1ns / 1ps

package cdud_pkg;

    // command codes carried in s_tuser
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_NEXT    = 2'd1;
    localparam logic [1:0] CMD_PREV    = 2'd2;
    localparam logic [1:0] CMD_COMPARE = 2'd3;

    localparam logic [13:0] YEAR_MIN     = 14'd1000;
    localparam logic [13:0] YEAR_MAX     = 14'd9999;
    localparam logic [13:0] YEAR_DEFAULT = 14'd2019;
    localparam logic [4:0]  DAY_DEFAULT  = 5'd1;
    localparam logic [3:0]  MONTH_DEFAULT = 4'd1;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;
    localparam logic [3:0]  MONTH_DEC    = 4'd12;
    localparam logic [5:0]  DAY_LIMIT    = 6'd31;

    // inverse of 25 modulo 2**14 and the largest product of a multiple of 25
    localparam logic [13:0] LEAP_INV25    = 14'd7209;
    localparam logic [13:0] LEAP_DIV25_MAX = 14'd655;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } cdud_date_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [13:0] in_year;
        logic [3:0]  in_month;
        logic [5:0]  in_day;
    } cdud_item_t;

    typedef struct packed {
        cdud_date_t date;
        logic       is_before;
        logic       is_equal;
        logic       day_fixed;
        logic       month_fixed;
        logic       year_fixed;
    } cdud_result_t;

    // gregorian leap rule; divisibility by 25 via the modular inverse
    function automatic logic is_leap(input logic [13:0] year);
        logic [13:0] prod;
        logic        div4;
        logic        div16;
        logic        div25;
        prod  = 14'(year * LEAP_INV25);
        div4  = (year[1:0] == 2'd0);
        div16 = (year[3:0] == 4'd0);
        div25 = (prod <= LEAP_DIV25_MAX);
        return (div4 && div25) ? div16 : div4;
    endfunction

    // month length, month in 1..12
    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ hdl/cdud_step.sv @@
`timescale 1ns / 1ps

module cdud_step
(
    input  cdud_pkg::cdud_item_t   item,
    input  cdud_pkg::cdud_date_t   cur,
    output cdud_pkg::cdud_result_t result
);

    logic        load_day_bad;
    logic        load_month_bad;
    logic        load_year_bad;
    logic [3:0]  load_month;
    logic [13:0] load_year;
    logic [4:0]  load_day;
    logic [4:0]  load_dim;
    logic        load_day_long;
    logic        cur_leap;
    logic [4:0]  cur_dim;
    logic [3:0]  prev_month;
    logic [13:0] prev_year;

    // range checks on the load request
    assign load_day_bad   = (item.in_day == 6'd0) || (item.in_day > cdud_pkg::DAY_LIMIT);
    assign load_month_bad = (item.in_month == 4'd0) || (item.in_month > cdud_pkg::MONTH_DEC);
    assign load_year_bad  = (item.in_year < cdud_pkg::YEAR_MIN)
                         || (item.in_year > cdud_pkg::YEAR_MAX);
    assign load_month     = load_month_bad ? cdud_pkg::MONTH_DEFAULT : item.in_month;
    assign load_year      = load_year_bad ? cdud_pkg::YEAR_DEFAULT : item.in_year;
    assign load_day       = load_day_bad ? cdud_pkg::DAY_DEFAULT : item.in_day[4:0];
    assign load_dim       = cdud_pkg::days_in(load_month, cdud_pkg::is_leap(load_year));
    assign load_day_long  = (load_day > load_dim);

    // current month length; a step back changes the year only into december
    assign cur_leap   = cdud_pkg::is_leap(cur.year);
    assign cur_dim    = cdud_pkg::days_in(cur.month, cur_leap);
    assign prev_month = (cur.month <= 4'd1) ? cdud_pkg::MONTH_DEC : cur.month - 4'd1;
    assign prev_year  = (cur.month > 4'd1) ? cur.year
                      : ((cur.year <= cdud_pkg::YEAR_MIN) ? cdud_pkg::YEAR_MAX
                                                          : cur.year - 14'd1);

    always_comb
    begin
        result = '0;

        // compare the held date against the raw request fields
        if (cur.year != item.in_year)
        begin
            result.is_before = (cur.year < item.in_year);
        end
        else if (cur.month != item.in_month)
        begin
            result.is_before = (cur.month < item.in_month);
        end
        else
        begin
            result.is_before = ({1'b0, cur.day} < item.in_day);
        end
        result.is_equal = (cur.year == item.in_year) && (cur.month == item.in_month)
                       && ({1'b0, cur.day} == item.in_day);

        result.date = cur;
        case (item.cmd)
            cdud_pkg::CMD_LOAD:
            begin
                result.date.year   = load_year;
                result.date.month  = load_month;
                result.date.day    = load_day_long ? cdud_pkg::DAY_DEFAULT : load_day;
                result.day_fixed   = load_day_bad || load_day_long;
                result.month_fixed = load_month_bad;
                result.year_fixed  = load_year_bad;
            end
            cdud_pkg::CMD_NEXT:
            begin
                if (cur.day >= cur_dim)
                begin
                    result.date.day = cdud_pkg::DAY_DEFAULT;
                    if (cur.month >= cdud_pkg::MONTH_DEC)
                    begin
                        result.date.month = cdud_pkg::MONTH_DEFAULT;
                        result.date.year  = (cur.year >= cdud_pkg::YEAR_MAX)
                                          ? cdud_pkg::YEAR_MIN : cur.year + 14'd1;
                    end
                    else
                    begin
                        result.date.month = cur.month + 4'd1;
                    end
                end
                else
                begin
                    result.date.day = cur.day + 5'd1;
                end
            end
            cdud_pkg::CMD_PREV:
            begin
                if (cur.day <= 5'd1)
                begin
                    result.date.month = prev_month;
                    result.date.year  = prev_year;
                    result.date.day   = cdud_pkg::days_in(prev_month, cur_leap);
                end
                else
                begin
                    result.date.day = cur.day - 5'd1;
                end
            end
            cdud_pkg::CMD_COMPARE:
            begin
                result.date = cur;
            end
            default:
            begin
                result.date = cur;
            end
        endcase
    end

endmodule

@@ hdl/calendar_date_up_down_counter.sv @@
`timescale 1ns / 1ps

// Gregorian date counter (years 1000..9999) that loads, steps forward or back
// by one day, or only compares, one request per clock with no bubbles unless
// m_tready stalls the output. Each request is captured in an input register,
// and the step logic then updates the held date and the result register
// together once the result register is free or being emptied. The rate of one
// request per cycle is set by the held-date feedback loop through that step
// logic. After reset the date is 1 January 2019. Every result also reports how
// the date held before the request compares with the request's raw date fields.
module calendar_date_up_down_counter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // in_day[5:0], in_month[9:6], in_year[23:10]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // out_day[4:0], out_month[8:5], out_year[22:9],
                                   // is_before[23], is_equal[24], day_fixed[25],
                                   // month_fixed[26], year_fixed[27], zero[31:28]
);

    logic                   in_valid_reg;
    cdud_pkg::cdud_item_t   in_item_reg;
    logic                   out_valid_reg;
    cdud_pkg::cdud_result_t out_result_reg;
    cdud_pkg::cdud_date_t   date_reg;
    cdud_pkg::cdud_date_t   date_next;
    cdud_pkg::cdud_result_t step_result;
    logic                   advance;

    // the step moves when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.cmd      <= s_tuser;
            in_item_reg.in_day   <= s_tdata[5:0];
            in_item_reg.in_month <= s_tdata[9:6];
            in_item_reg.in_year  <= s_tdata[23:10];
        end
    end

    cdud_step u_step
    (
        .item   (in_item_reg),
        .cur    (date_reg),
        .result (step_result)
    );

    // held date
    assign date_next = advance ? step_result.date : date_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_reg.day   <= cdud_pkg::DAY_DEFAULT;
            date_reg.month <= cdud_pkg::MONTH_DEFAULT;
            date_reg.year  <= cdud_pkg::YEAR_DEFAULT;
        end
        else
        begin
            date_reg <= date_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       out_result_reg.year_fixed,
                       out_result_reg.month_fixed,
                       out_result_reg.day_fixed,
                       out_result_reg.is_equal,
                       out_result_reg.is_before,
                       out_result_reg.date.year,
                       out_result_reg.date.month,
                       out_result_reg.date.day};

    // held date fields stay within their legal ranges
    assert property (@(posedge clk) disable iff (!rst_n)
        (date_reg.month >= 4'd1) && (date_reg.month <= cdud_pkg::MONTH_DEC)
        && (date_reg.day >= 5'd1)
        && (date_reg.year >= cdud_pkg::YEAR_MIN) && (date_reg.year <= cdud_pkg::YEAR_MAX))
        else $error("held date out of range");

    // held date only moves when a request is stepped
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(date_reg))
        else $error("held date changed without a step");

    // a pending result always shows the held date
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_result_reg.date == date_reg))
        else $error("result date differs from held date");

    // fix flags only come from a load
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_item_reg.cmd != cdud_pkg::CMD_LOAD))
        |=> !(out_result_reg.day_fixed || out_result_reg.month_fixed
              || out_result_reg.year_fixed))
        else $error("fix flag set outside load");

endmodule
